>>> rtl/sacl_pkg.sv
// shared constants, types and helpers for the set-associative cache lookup
package sacl_pkg;

   // fixed field widths
   localparam int ADDR_W   = 48;
   localparam int CNT_W    = 32;
   localparam int AGE_W    = 3;
   localparam int LIMIT_W  = AGE_W + 1;
   localparam int OFFS_W   = 4;
   localparam int IDXB_W   = 3;
   localparam int WAYS_W   = 4;
   localparam int SHAMT_W  = 5;
   localparam int CSR_DW   = 32;
   localparam int CSR_AW   = 4;

   // raw set index before folding onto the sets present
   localparam int RAW_IDX_W = 7;
   localparam int RAW_SETS  = 1 << RAW_IDX_W;

   localparam logic [AGE_W-1:0]   AGE_MAX   = '1;
   localparam logic [LIMIT_W-1:0] AGE_LIMIT = LIMIT_W'(1) << AGE_W;
   localparam logic [CNT_W-1:0]   CNT_MAX   = '1;

   // parameter defaults
   localparam int DEF_NUM_SETS  = 64;
   localparam int DEF_NUM_WAYS  = 8;
   localparam int DEF_ADDR_BITS = 48;

   // access kind
   localparam logic MODE_WRITE = 1'b1;

   typedef enum logic {
      POLICY_LRU  = 1'b0,
      POLICY_FIFO = 1'b1
   } policy_type;

   typedef enum logic [1:0] {
      REG_POLICY = 2'd0,
      REG_OFFSET = 2'd1,
      REG_INDEX  = 2'd2,
      REG_WAYS   = 2'd3
   } csr_reg_type;

   // register reset values
   localparam logic [OFFS_W-1:0] RST_OFFSET = 4'd2;
   localparam logic [IDXB_W-1:0] RST_INDEX  = 3'd0;
   localparam logic [WAYS_W-1:0] RST_WAYS   = 4'd1;

   // control from the top level into the set update logic
   typedef struct packed {
      policy_type        policy;
      logic [WAYS_W-1:0] ways_in_use;
   } upd_ctrl_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      sat_inc = (v == CNT_MAX) ? v : v + CNT_W'(1);
   endfunction

endpackage

>>> rtl/sacl_set_update.sv
// tag compare, victim choice and age update for one set row
module sacl_set_update
   import sacl_pkg::*;
#(
   parameter int NUM_WAYS = DEF_NUM_WAYS,
   parameter int TAG_W    = ADDR_W
) (
   input  logic [NUM_WAYS*(1+AGE_W+TAG_W)-1:0] row_in,
   input  logic [TAG_W-1:0]                    tag_in,
   input  upd_ctrl_type                        ctrl,
   output logic [NUM_WAYS*(1+AGE_W+TAG_W)-1:0] row_out,
   output logic                                hit
);

   typedef struct packed {
      logic             valid;
      logic [AGE_W-1:0] age;
      logic [TAG_W-1:0] tag;
   } way_type;

   way_type [NUM_WAYS-1:0] ways_rd;
   way_type [NUM_WAYS-1:0] ways_wr;

   logic [NUM_WAYS-1:0] en;
   logic [NUM_WAYS-1:0] match;
   logic [NUM_WAYS-1:0] inval;
   logic [NUM_WAYS-1:0] hit_oh;
   logic [NUM_WAYS-1:0] fill_oh;
   logic [NUM_WAYS-1:0] victim_oh;
   logic [NUM_WAYS-1:0] sel;
   logic                any_inv;
   logic                do_age;
   logic [AGE_W-1:0]    sel_age;
   logic [LIMIT_W-1:0]  limit;

   assign ways_rd = row_in;
   assign row_out = ways_wr;

   always_comb begin
      for (int i = 0; i < NUM_WAYS; i++) begin
         en[i]    = (i == 0) || (i < int'(ctrl.ways_in_use));
         match[i] = en[i] && ways_rd[i].valid && (ways_rd[i].tag == tag_in);
         inval[i] = en[i] && !ways_rd[i].valid;
      end
   end

   // lowest set bit
   assign hit_oh  = match & (~match + NUM_WAYS'(1));
   assign fill_oh = inval & (~inval + NUM_WAYS'(1));
   assign hit     = |match;
   assign any_inv = |inval;

   // oldest way in use, lowest number on a tie
   always_comb begin
      for (int i = 0; i < NUM_WAYS; i++) begin
         victim_oh[i] = en[i];
         for (int j = 0; j < NUM_WAYS; j++) begin
            if (j < i && en[j] && !(ways_rd[j].age < ways_rd[i].age)) begin
               victim_oh[i] = 1'b0;
            end
            if (j > i && en[j] && (ways_rd[j].age > ways_rd[i].age)) begin
               victim_oh[i] = 1'b0;
            end
         end
      end
   end

   assign sel = hit ? hit_oh : (any_inv ? fill_oh : victim_oh);

   always_comb begin
      sel_age = '0;
      for (int i = 0; i < NUM_WAYS; i++) begin
         sel_age = sel_age | (ways_rd[i].age & {AGE_W{sel[i]}});
      end
   end

   // a fresh fill ages every valid way, otherwise only the younger ones; a FIFO hit ages none
   assign limit  = (!hit && any_inv) ? AGE_LIMIT : {1'b0, sel_age};
   assign do_age = !(hit && (ctrl.policy == POLICY_FIFO));

   always_comb begin
      for (int i = 0; i < NUM_WAYS; i++) begin
         ways_wr[i] = ways_rd[i];
         if (do_age) begin
            if (sel[i]) begin
               ways_wr[i].age = '0;
            end else if (en[i] && ways_rd[i].valid && ({1'b0, ways_rd[i].age} < limit)
                         && (ways_rd[i].age != AGE_MAX)) begin
               ways_wr[i].age = ways_rd[i].age + AGE_W'(1);
            end
         end
         if (sel[i] && !hit) begin
            ways_wr[i].valid = 1'b1;
            ways_wr[i].tag   = tag_in;
         end
      end
   end

endmodule

>>> rtl/set_assoc_cache_lookup.sv
// Set-associative cache lookup, write-through and write-allocate, LRU or FIFO
// replacement. One set row (tag, valid bit and age rank of every way) is one
// word of a single-port-style synchronous memory. On the accepting edge the set
// row is read into a register; in the lookup state the tags are compared and the
// way picked, and once the result slot is free the updated row is written back
// and the result register loaded; the next request is taken in the cycle after
// that, and later still while an earlier result is held by rsp_stall. After reset
// a clearing pass writes every row invalid before the first request is taken. The
// four running counters on the result side are valid along with rsp_valid.
module set_assoc_cache_lookup
   import sacl_pkg::*;
#(
   parameter int NUM_SETS  = DEF_NUM_SETS,
   parameter int NUM_WAYS  = DEF_NUM_WAYS,
   parameter int ADDR_BITS = DEF_ADDR_BITS
) (
   input  logic              clock,
   input  logic              reset,

   input  logic              req_valid,
   output logic              req_stall,
   input  logic [ADDR_W-1:0] req_address,
   input  logic              req_mode,

   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_hit,
   output logic              rsp_mem_read,
   output logic              rsp_mem_write,
   output logic [CNT_W-1:0]  rsp_hit_count,
   output logic [CNT_W-1:0]  rsp_miss_count,
   output logic [CNT_W-1:0]  rsp_read_count,
   output logic [CNT_W-1:0]  rsp_write_count,

   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready
);

   localparam int TAG_W = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
   localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
   localparam int ROW_W = NUM_WAYS * (1 + AGE_W + TAG_W);

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_LOOK  = 3'b100
   } state_type;

   typedef logic [SET_W-1:0] set_tab_type [RAW_SETS];

   // fold of the raw index onto the sets present
   function automatic set_tab_type build_set_tab();
      set_tab_type t;
      for (int i = 0; i < RAW_SETS; i++) begin
         t[i] = SET_W'(i % NUM_SETS);
      end
      return t;
   endfunction

   localparam set_tab_type SET_TAB = build_set_tab();

   // configuration
   policy_type        policy_ff;
   logic [OFFS_W-1:0] offset_ff;
   logic [IDXB_W-1:0] index_ff;
   logic [WAYS_W-1:0] ways_ff;
   logic              csr_wr;
   csr_reg_type       csr_sel;

   // control
   state_type         state_ff, state_in;
   logic [SET_W-1:0]  clr_ff, clr_in;
   logic              req_accept;
   logic              rsp_accept;
   logic              look_done;

   // request fields
   logic [TAG_W-1:0]     addr_m;
   logic [SHAMT_W-1:0]   tag_shamt;
   logic [RAW_IDX_W-1:0] idx_mask;
   logic [RAW_IDX_W-1:0] raw_idx;
   logic [SET_W-1:0]     set_in;
   logic [TAG_W-1:0]     tag_in;
   logic [SET_W-1:0]     set_ff;
   logic [TAG_W-1:0]     tag_ff;
   logic                 mode_ff;

   // set memory
   logic [ROW_W-1:0] row_mem [NUM_SETS];
   logic [ROW_W-1:0] rd_row_ff;
   logic [ROW_W-1:0] upd_row;
   logic             upd_hit;
   logic             mem_we;
   logic [SET_W-1:0] mem_waddr;
   logic [ROW_W-1:0] mem_wdata;
   upd_ctrl_type     upd_ctrl;

   // results
   logic             rsp_valid_ff;
   logic             rsp_hit_ff;
   logic             rsp_mode_ff;
   logic [CNT_W-1:0] hit_cnt_ff;
   logic [CNT_W-1:0] miss_cnt_ff;
   logic [CNT_W-1:0] read_cnt_ff;
   logic [CNT_W-1:0] write_cnt_ff;

   // ---------------------------------------------------------------- csr port
   assign pready  = 1'b1;
   assign csr_sel = csr_reg_type'(paddr[3:2]);
   assign csr_wr  = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= POLICY_LRU;
         offset_ff <= RST_OFFSET;
         index_ff  <= RST_INDEX;
         ways_ff   <= RST_WAYS;
      end else if (csr_wr) begin
         unique case (csr_sel)
            REG_POLICY: policy_ff <= policy_type'(pwdata[0]);
            REG_OFFSET: offset_ff <= pwdata[OFFS_W-1:0];
            REG_INDEX:  index_ff  <= pwdata[IDXB_W-1:0];
            REG_WAYS:   ways_ff   <= pwdata[WAYS_W-1:0];
            default:    ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_sel)
         REG_POLICY: prdata = CSR_DW'(policy_ff);
         REG_OFFSET: prdata = CSR_DW'(offset_ff);
         REG_INDEX:  prdata = CSR_DW'(index_ff);
         REG_WAYS:   prdata = CSR_DW'(ways_ff);
         default:    prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- control
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid_ff && !rsp_stall;
   assign look_done  = (state_ff == ST_LOOK) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + SET_W'(1);
            if (clr_ff == SET_W'(NUM_SETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (look_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   // ---------------------------------------------------------------- address split
   assign addr_m    = req_address[TAG_W-1:0];
   assign tag_shamt = SHAMT_W'(offset_ff) + SHAMT_W'(index_ff);
   assign tag_in    = addr_m >> tag_shamt;
   assign idx_mask  = RAW_IDX_W'((8'd1 << index_ff) - 8'd1);
   assign raw_idx   = RAW_IDX_W'(addr_m >> offset_ff) & idx_mask;
   assign set_in    = SET_TAB[raw_idx];

   always_ff @(posedge clock) begin
      if (req_accept) begin
         set_ff  <= set_in;
         tag_ff  <= tag_in;
         mode_ff <= req_mode;
      end
   end

   // ---------------------------------------------------------------- set memory
   assign mem_we    = (state_ff == ST_CLEAR) || look_done;
   assign mem_waddr = (state_ff == ST_CLEAR) ? clr_ff : set_ff;
   assign mem_wdata = (state_ff == ST_CLEAR) ? '0 : upd_row;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         row_mem[mem_waddr] <= mem_wdata;
      end
      if (req_accept) begin
         rd_row_ff <= row_mem[set_in];
      end
   end

   assign upd_ctrl.policy      = policy_ff;
   assign upd_ctrl.ways_in_use = ways_ff;

   sacl_set_update #(
      .NUM_WAYS (NUM_WAYS),
      .TAG_W    (TAG_W)
   ) u_set_update (
      .row_in  (rd_row_ff),
      .tag_in  (tag_ff),
      .ctrl    (upd_ctrl),
      .row_out (upd_row),
      .hit     (upd_hit)
   );

   // ---------------------------------------------------------------- results
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         hit_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
         read_cnt_ff  <= '0;
         write_cnt_ff <= '0;
      end else if (look_done) begin
         rsp_valid_ff <= 1'b1;
         if (upd_hit) begin
            hit_cnt_ff <= sat_inc(hit_cnt_ff);
         end else begin
            miss_cnt_ff <= sat_inc(miss_cnt_ff);
            read_cnt_ff <= sat_inc(read_cnt_ff);
         end
         if (mode_ff == MODE_WRITE) begin
            write_cnt_ff <= sat_inc(write_cnt_ff);
         end
      end else if (rsp_accept) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (look_done) begin
         rsp_hit_ff  <= upd_hit;
         rsp_mode_ff <= mode_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_mem_read    = !rsp_hit_ff;
   assign rsp_mem_write   = (rsp_mode_ff == MODE_WRITE);
   assign rsp_hit_count   = hit_cnt_ff;
   assign rsp_miss_count  = miss_cnt_ff;
   assign rsp_read_count  = read_cnt_ff;
   assign rsp_write_count = write_cnt_ff;

   // ---------------------------------------------------------------- checks
   a_accept_to_look: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_LOOK))
      else $error("accepted request did not start a lookup");

   a_rsp_from_look: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_LOOK))
      else $error("result raised outside a lookup");

   a_miss_counts: assert property (@(posedge clock) disable iff (reset)
      look_done && !upd_hit && (miss_cnt_ff != CNT_MAX)
      |=> (miss_cnt_ff == CNT_W'($past(miss_cnt_ff) + CNT_W'(1))))
      else $error("miss not counted");

   a_no_clear_write_in_look: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOK) && !look_done |-> !mem_we)
      else $error("set row written while result slot busy");

endmodule

>>> tb/sv/set_assoc_cache_lookup_test.sv
// self-checking testbench for the set-associative cache lookup
module set_assoc_cache_lookup_test
   import sacl_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_SETS = DEF_NUM_SETS;
   localparam int NUM_WAYS = DEF_NUM_WAYS;
   localparam int PHASES = 8;
   localparam int PHASE_ITEMS = 167;
   localparam int LONG_HOLD = 150;
   localparam logic MODE_READ = ~MODE_WRITE;

   // cache settings walked through by the random part
   localparam policy_type SET_POLICY [PHASES] = '{POLICY_LRU, POLICY_FIFO, POLICY_LRU,
      POLICY_FIFO, POLICY_LRU, POLICY_FIFO, POLICY_LRU, POLICY_FIFO};
   localparam int SET_OFFSET [PHASES] = '{0, 12, 15, 2, 5, 0, 12, 7};
   localparam int SET_INDEX [PHASES] = '{0, 6, 7, 3, 6, 7, 0, 1};
   localparam int SET_WAYS [PHASES] = '{8, 4, 15, 0, 8, 8, 2, 9};

   typedef struct packed {
      logic [ADDR_W-1:0] address;
      logic mode;
   } access_type;

   typedef struct packed {
      logic hit;
      logic mem_read;
      logic mem_write;
      logic [CNT_W-1:0] hit_count;
      logic [CNT_W-1:0] miss_count;
      logic [CNT_W-1:0] read_count;
      logic [CNT_W-1:0] write_count;
   } lookup_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic req_valid = 1'b0;
   logic req_stall;
   logic [ADDR_W-1:0] req_address = '0;
   logic req_mode = MODE_READ;

   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_hit;
   logic rsp_mem_read;
   logic rsp_mem_write;
   logic [CNT_W-1:0] rsp_hit_count;
   logic [CNT_W-1:0] rsp_miss_count;
   logic [CNT_W-1:0] rsp_read_count;
   logic [CNT_W-1:0] rsp_write_count;

   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [CSR_AW-1:0] paddr = '0;
   logic [CSR_DW-1:0] pwdata = '0;
   logic [CSR_DW-1:0] prdata;
   logic pready;

   // model of the cache contents and settings
   policy_type cfg_policy = POLICY_LRU;
   logic [OFFS_W-1:0] cfg_offset = RST_OFFSET;
   logic [IDXB_W-1:0] cfg_index = RST_INDEX;
   logic [WAYS_W-1:0] cfg_ways = RST_WAYS;
   bit line_valid [NUM_SETS][NUM_WAYS];
   logic [ADDR_W-1:0] line_tag [NUM_SETS][NUM_WAYS];
   bit [AGE_W-1:0] line_age [NUM_SETS][NUM_WAYS];
   logic [CNT_W-1:0] hit_total = '0;
   logic [CNT_W-1:0] miss_total = '0;
   logic [CNT_W-1:0] read_total = '0;
   logic [CNT_W-1:0] write_total = '0;

   access_type access_queue[$];
   lookup_type lookups_due[$];
   int unsigned gap_left = 0;
   int unsigned stall_left = 0;
   int unsigned mismatches = 0;
   int unsigned lookups_checked = 0;
   bit steady = 1'b0;
   bit hold_req = 1'b0;

   set_assoc_cache_lookup dut (.*);

   always #4 clock = ~clock;

   function automatic int unsigned pick_gap();
      int unsigned r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // the chosen way becomes youngest, valid ways younger than limit age by one
   function automatic void promote_way(int unsigned set_no, int unsigned nways,
                                       int unsigned way, int unsigned limit);
      for (int unsigned i = 0; i < nways; i++) begin
         if (i != way && line_valid[set_no][i] && line_age[set_no][i] < limit &&
             line_age[set_no][i] != AGE_MAX)
            line_age[set_no][i] = line_age[set_no][i] + 1'b1;
      end
      line_age[set_no][way] = '0;
   endfunction

   function automatic void predict_lookup(input logic [ADDR_W-1:0] addr, input logic mode);
      lookup_type res;
      int unsigned set_no, nways, way, victim;
      logic [63:0] raw;
      logic [ADDR_W-1:0] tag;
      bit found, filled;
      nways = (cfg_ways == 0) ? 1 : ((cfg_ways > NUM_WAYS) ? NUM_WAYS : cfg_ways);
      raw = (64'(addr) >> cfg_offset) & ((64'd1 << cfg_index) - 64'd1);
      set_no = raw % NUM_SETS;
      tag = addr >> (int'(cfg_offset) + int'(cfg_index));
      found = 1'b0;
      way = 0;
      for (int unsigned i = 0; i < nways && !found; i++) begin
         if (line_valid[set_no][i] && line_tag[set_no][i] == tag) begin
            found = 1'b1;
            way = i;
         end
      end
      if (found) begin
         hit_total = (hit_total == CNT_MAX) ? hit_total : hit_total + 1'b1;
         if (cfg_policy == POLICY_LRU)
            promote_way(set_no, nways, way, line_age[set_no][way]);
      end else begin
         miss_total = (miss_total == CNT_MAX) ? miss_total : miss_total + 1'b1;
         read_total = (read_total == CNT_MAX) ? read_total : read_total + 1'b1;
         filled = 1'b0;
         for (int unsigned i = 0; i < nways && !filled; i++) begin
            if (!line_valid[set_no][i]) begin
               line_valid[set_no][i] = 1'b1;
               line_tag[set_no][i] = tag;
               promote_way(set_no, nways, i, AGE_MAX + 1);
               filled = 1'b1;
            end
         end
         if (!filled) begin
            // oldest way goes, lowest number on a tie
            victim = 0;
            for (int unsigned i = 1; i < nways; i++)
               if (line_age[set_no][i] > line_age[set_no][victim]) victim = i;
            line_tag[set_no][victim] = tag;
            promote_way(set_no, nways, victim, line_age[set_no][victim]);
         end
      end
      if (mode == MODE_WRITE)
         write_total = (write_total == CNT_MAX) ? write_total : write_total + 1'b1;
      res.hit = found;
      res.mem_read = !found;
      res.mem_write = (mode == MODE_WRITE);
      res.hit_count = hit_total;
      res.miss_count = miss_total;
      res.read_count = read_total;
      res.write_count = write_total;
      lookups_due.push_back(res);
   endfunction

   function automatic void compare_field(string field, logic [CNT_W-1:0] want,
                                         logic [CNT_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         mismatches++;
      end
   endfunction

   // request driver
   always @(posedge clock) begin
      access_type nxt;
      int unsigned gap;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left <= 0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            predict_lookup(req_address, req_mode);
            gap = pick_gap();
         end else begin
            gap = gap_left;
         end
         if (gap > 0 || access_queue.size() == 0) begin
            req_valid <= 1'b0;
            gap_left <= (gap > 0) ? gap - 1 : 0;
         end else begin
            nxt = access_queue.pop_front();
            req_valid <= 1'b1;
            req_address <= nxt.address;
            req_mode <= nxt.mode;
            gap_left <= 0;
         end
      end
   end

   // result monitor and receiver stalls
   always @(posedge clock) begin
      lookup_type due;
      int unsigned n;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (lookups_due.size() == 0) begin
               $display("%0t: unexpected lookup result, expected none, actual hit=%0b",
                        $time, rsp_hit);
               mismatches++;
            end else begin
               due = lookups_due.pop_front();
               compare_field("hit", due.hit, rsp_hit);
               compare_field("mem_read", due.mem_read, rsp_mem_read);
               compare_field("mem_write", due.mem_write, rsp_mem_write);
               compare_field("hit_count", due.hit_count, rsp_hit_count);
               compare_field("miss_count", due.miss_count, rsp_miss_count);
               compare_field("read_count", due.read_count, rsp_read_count);
               compare_field("write_count", due.write_count, rsp_write_count);
               lookups_checked++;
            end
         end
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
         end else if (hold_req) begin
            hold_req = 1'b0;
            rsp_stall <= 1'b1;
            stall_left <= LONG_HOLD;
         end else begin
            n = pick_gap();
            rsp_stall <= (n != 0);
            stall_left <= (n != 0) ? n - 1 : $urandom_range(0, 4);
         end
      end
   end

   task automatic write_register(input csr_reg_type which, input logic [3:0] value);
      logic [CSR_DW-1:0] data, kept, seen;
      data = $urandom();
      case (which)
         REG_POLICY: begin
            data[0] = value[0];
            kept = CSR_DW'(value[0]);
            cfg_policy = policy_type'(value[0]);
         end
         REG_OFFSET: begin
            data[OFFS_W-1:0] = value;
            kept = CSR_DW'(value);
            cfg_offset = value;
         end
         REG_INDEX: begin
            data[IDXB_W-1:0] = value[IDXB_W-1:0];
            kept = CSR_DW'(value[IDXB_W-1:0]);
            cfg_index = value[IDXB_W-1:0];
         end
         default: begin
            data[WAYS_W-1:0] = value;
            kept = CSR_DW'(value);
            cfg_ways = value;
         end
      endcase
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CSR_AW'(4 * int'(which));
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      // read the register back
      @(posedge clock);
      psel <= 1'b1;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      seen = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      if (seen !== kept) begin
         $display("%0t: register %s readback, expected %0h, actual %0h",
                  $time, which.name(), kept, seen);
         mismatches++;
      end
   endtask

   task automatic queue_access(input logic [ADDR_W-1:0] address, input logic mode);
      access_queue.push_back('{address: address, mode: mode});
   endtask

   // mostly accesses to a few sets with a handful of tags, so sets fill and evict
   task automatic queue_random(input int unsigned count);
      logic [63:0] tags [12];
      logic [6:0] sets [4];
      logic [63:0] a;
      int unsigned sh;
      sh = int'(cfg_offset) + int'(cfg_index);
      foreach (tags[k]) tags[k] = (k < 6) ? 64'($urandom_range(0, 15)) : {$urandom(), $urandom()};
      foreach (sets[k]) sets[k] = $urandom_range(0, 127);
      repeat (count) begin
         if ($urandom_range(0, 99) < 80)
            a = (tags[$urandom_range(0, 11)] << sh) |
                ((64'(sets[$urandom_range(0, 3)]) & ((64'd1 << cfg_index) - 64'd1))
                 << cfg_offset) |
                ({$urandom(), $urandom()} & ((64'd1 << cfg_offset) - 64'd1));
         else
            a = {$urandom(), $urandom()};
         queue_access(a[ADDR_W-1:0], logic'($urandom_range(0, 1)));
      end
   endtask

   task automatic wait_idle();
      while (access_queue.size() != 0 || req_valid || lookups_due.size() != 0)
         @(negedge clock);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      // directed accesses under the reset settings: one way, 4-byte blocks
      queue_access('0, MODE_READ);
      queue_access('0, MODE_WRITE);
      queue_access(48'h3, MODE_READ);
      queue_access(48'h4, MODE_READ);
      queue_access('1, MODE_WRITE);
      queue_access(48'hFFFF_FFFF_FFFC, MODE_READ);
      queue_access(48'h8000_0000_0000, MODE_WRITE);
      queue_access(48'h8000_0000_0003, MODE_READ);
      queue_access(48'h7FFF_FFFF_FFFF, MODE_READ);
      queue_access(48'h5555_5555_5555, MODE_WRITE);
      queue_access(48'hAAAA_AAAA_AAAA, MODE_READ);
      for (int b = 0; b < ADDR_W; b += 6)
         queue_access(ADDR_W'(1) << b, (b % 12 == 0) ? MODE_WRITE : MODE_READ);
      for (int p = 0; p < PHASES; p++) begin
         wait_idle();
         write_register(REG_POLICY, 4'(SET_POLICY[p]));
         write_register(REG_OFFSET, 4'(SET_OFFSET[p]));
         write_register(REG_INDEX, 4'(SET_INDEX[p]));
         write_register(REG_WAYS, 4'(SET_WAYS[p]));
         @(negedge clock);
         steady = (p == 0 || p == 5);
         // receiver holds off long enough for the block to back up
         if (p == 2) hold_req = 1'b1;
         if (p == 4) begin
            queue_random(PHASE_ITEMS / 2);
            wait_idle();
            queue_random(PHASE_ITEMS - PHASE_ITEMS / 2);
         end else begin
            queue_random(PHASE_ITEMS);
         end
      end
      wait_idle();
      repeat (20) @(posedge clock);
      $display("checked %0d lookups (%0d hits, %0d misses, %0d write-throughs)",
               lookups_checked, hit_total, miss_total, write_total);
      $display("over %0d cache settings with both replacement policies", PHASES + 1);
      if (mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      #8_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
